FILE: src/rpm_led_bar_graph_top_macros.svh
// ----------------------------------------------------------------------------
// rpm_led_bar_graph_top_macros.svh
// Assertion macros for the LED bar-graph meter. They compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef RPM_LED_BAR_GRAPH_TOP_MACROS_SVH
`define RPM_LED_BAR_GRAPH_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication under reset.
`define RLBG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication under reset.
`define RLBG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RLBG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RLBG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/rlbg_pkg.sv
// ----------------------------------------------------------------------------
// rlbg_pkg
// Shared constants, types and the hue gradient table of the LED bar-graph meter.
// ----------------------------------------------------------------------------
package rlbg_pkg;

	// Strip geometry.
	localparam int LED_COUNT  = 53;
	localparam int HALF_COUNT = LED_COUNT / 2;
	localparam int LED_MAX    = 64;
	localparam int IDX_W      = 6;

	// Field widths.
	localparam int SPEED_W = 16;
	localparam int HUE_W   = 8;
	localparam int LEVEL_W = 8;
	localparam logic [SPEED_W-1:0] IDLE_RESET = 16'd178;

	// Fill arithmetic: fill = 128 * HALF * num / den, saturated.
	localparam int FULL_LEVEL = 128;
	localparam int FILL_SCALE = FULL_LEVEL * HALF_COUNT;
	localparam int FILL_MAX   = FILL_SCALE;
	localparam int FILL_W     = $clog2(FILL_MAX + 1) + 1;
	localparam int LV_W       = FILL_W + 2;
	localparam int SCALE_W    = $clog2(FILL_SCALE + 1);

	// Divider: magnitude of the scaled numerator over the magnitude of the span.
	localparam int DVD_W = SPEED_W + SCALE_W;
	localparam int DVS_W = SPEED_W;
	localparam int DCNT_W = $clog2(DVD_W + 1);

	// Blink threshold 19/20, compared as 20*num against 19*den.
	localparam int CMP_W = SPEED_W + 6;
	localparam int THR_NUM = 20;
	localparam int THR_DEN = 19;

	localparam logic [HUE_W-1:0] BLINK_HUE = 8'd255;

	// Divider status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Gradient table, built at elaboration.
	typedef logic [HUE_W-1:0] hue_lut_t [0:LED_MAX-1];

	function automatic hue_lut_t build_hue_lut();
		hue_lut_t lut;
		int       i;
		for (i = 0; i < LED_MAX; i++) begin
			if (i >= LED_COUNT) begin
				lut[i] = '0;
			end else if (i < HALF_COUNT) begin
				lut[i] = HUE_W'(170 + (85 * i) / HALF_COUNT);
			end else begin
				lut[i] = HUE_W'(255 - (85 * (i - HALF_COUNT)) / (LED_COUNT - HALF_COUNT));
			end
		end
		return lut;
	endfunction

	localparam hue_lut_t HUE_LUT = build_hue_lut();

endpackage

FILE: src/rlbg_div.sv
// ----------------------------------------------------------------------------
// rlbg_div
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rlbg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rlbg_pkg::DVD_W-1:0]   dividend,
	input  logic [rlbg_pkg::DVS_W-1:0]   divisor,
	output rlbg_pkg::div_stat_t          stat,
	output logic [rlbg_pkg::DVD_W-1:0]   quotient
);
	import rlbg_pkg::*;

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W+1:0]  diff;
	logic              qbit;

	// Shift in the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		qbit  = ~diff[DVS_W+1];
	end

	// Control: count the quotient bits and flag the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient share the shift.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

FILE: src/rpm_led_bar_graph_top.sv
// ----------------------------------------------------------------------------
// rpm_led_bar_graph_top
// LED bar-graph meter: turns one engine speed update into a hue and level
// for every LED of the strip.
// ----------------------------------------------------------------------------
// Usage:
// One input transaction (engine_speed, max_speed) on in_valid/in_ready starts
// an update. The block answers with one output transaction per LED, 53 in
// all, in index order, with last set on the final LED.
// The speed is normalized against idle_speed, written through cfg_wr_en and
// cfg_wr_data; reset loads 178. The user must write it only while the block
// is idle; the block itself does not enforce this.
// An update runs in steps: the operands are registered when the input is
// taken, the bit-serial divider forms the quotient (one quotient bit a
// cycle), the fill register takes the quotient and the output register
// loads the first LED. Each further LED follows in the next cycle when
// out_ready stays high, and in_ready rises right after the last LED is taken;
// with out_ready high the divider and the LED counter set an update's length.
// With an unknown maximum or a zero span the divider is skipped (zero fill).
// in_ready is high only when no update is in progress. A stalled receiver
// holds the current LED in the output register and the LED counter waits.
// Reset clears the sequencer, the output valid and the blink flag.
// ----------------------------------------------------------------------------
`include "rpm_led_bar_graph_top_macros.svh"

module rpm_led_bar_graph_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rlbg_pkg::SPEED_W-1:0]  cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rlbg_pkg::SPEED_W-1:0]  engine_speed,
	input  logic [rlbg_pkg::SPEED_W-1:0]  max_speed,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rlbg_pkg::IDX_W-1:0]    led_index,
	output logic [rlbg_pkg::HUE_W-1:0]    hue,
	output logic [rlbg_pkg::LEVEL_W-1:0]  level,
	output logic                          last
);
	import rlbg_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_DIV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [SPEED_W-1:0]         idle_q;
	logic                       blink_q;
	logic signed [SPEED_W:0]    num_q;
	logic signed [SPEED_W:0]    den_q;
	logic                       zero_q;
	logic                       neg_q;
	logic signed [FILL_W-1:0]   fill_q;
	logic [IDX_W-1:0]           cnt_q;
	logic                       cnt_done_q;

	logic                       out_valid_q;
	logic [IDX_W-1:0]           led_index_q;
	logic [HUE_W-1:0]           hue_q;
	logic [LEVEL_W-1:0]         level_q;
	logic                       last_q;

	logic                       in_fire;
	logic [SPEED_W-1:0]         num_mag;
	logic [SPEED_W-1:0]         den_mag;
	logic [DVD_W-1:0]           dividend;
	logic signed [CMP_W-1:0]    num_x;
	logic signed [CMP_W-1:0]    den_x;
	logic                       over;
	logic                       div_start;
	div_stat_t                  div_stat;
	logic [DVD_W-1:0]           quotient;
	logic signed [FILL_W-1:0]   fill_sat;
	logic [IDX_W-1:0]           led_dist;
	logic signed [LV_W-1:0]     lv;
	logic [LEVEL_W-1:0]         lv_clamp;
	logic [LEVEL_W-1:0]         lv_out;
	logic                       load;

	assign in_fire = in_valid && in_ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= IDLE_RESET;
		end else if (cfg_wr_en) begin
			idle_q <= cfg_wr_data;
		end
	end

	// Operand magnitudes, scaled numerator and blink threshold compare.
	always_comb begin
		num_mag  = num_q[SPEED_W] ? SPEED_W'(-num_q) : num_q[SPEED_W-1:0];
		den_mag  = den_q[SPEED_W] ? SPEED_W'(-den_q) : den_q[SPEED_W-1:0];
		dividend = DVD_W'(num_mag) * DVD_W'(FILL_SCALE);
		num_x    = CMP_W'(num_q) * CMP_W'(THR_NUM);
		den_x    = CMP_W'(den_q) * CMP_W'(THR_DEN);
		if (zero_q) begin
			over = 1'b0;
		end else if (!den_q[SPEED_W]) begin
			over = num_x > den_x;
		end else begin
			over = num_x < den_x;
		end
	end

	assign div_start = (state_q == S_PREP) && !zero_q;

	rlbg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_mag),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// Signed, saturated fill from the quotient magnitude.
	always_comb begin
		if (neg_q) begin
			if (quotient > DVD_W'(FULL_LEVEL)) begin
				fill_sat = -FILL_W'(FULL_LEVEL);
			end else begin
				fill_sat = -FILL_W'(quotient);
			end
		end else begin
			if (quotient > DVD_W'(FILL_MAX)) begin
				fill_sat = FILL_W'(FILL_MAX);
			end else begin
				fill_sat = FILL_W'(quotient);
			end
		end
	end

	// Level of the current LED from its distance to the nearer end.
	always_comb begin
		if (cnt_q < IDX_W'(HALF_COUNT)) begin
			led_dist = cnt_q;
		end else begin
			led_dist = IDX_W'(LED_COUNT - 1) - cnt_q;
		end
		lv = LV_W'(fill_q) + LV_W'(FULL_LEVEL) - $signed(LV_W'({led_dist, 7'd0}));
		if (lv < 0) begin
			lv_clamp = '0;
		end else if (lv > LV_W'(FULL_LEVEL)) begin
			lv_clamp = LEVEL_W'(FULL_LEVEL);
		end else begin
			lv_clamp = LEVEL_W'(lv);
		end
		lv_out = blink_q ? (lv_clamp + (lv_clamp >> 1)) : lv_clamp;
	end

	assign load = !out_valid_q || out_ready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			blink_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			cnt_done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					blink_q    <= over ? ~blink_q : 1'b0;
					cnt_q      <= '0;
					cnt_done_q <= 1'b0;
					state_q    <= zero_q ? S_EMIT : S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						if (cnt_done_q) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							out_valid_q <= 1'b1;
							cnt_q       <= cnt_q + 1'b1;
							if (cnt_q == IDX_W'(LED_COUNT - 1)) begin
								cnt_done_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand and fill registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			num_q  <= $signed({1'b0, engine_speed}) - $signed({1'b0, idle_q});
			den_q  <= $signed({1'b0, max_speed}) - $signed({1'b0, idle_q});
			zero_q <= (max_speed == '0) || (max_speed == idle_q);
		end
		if (state_q == S_PREP) begin
			neg_q  <= num_q[SPEED_W] ^ den_q[SPEED_W];
			fill_q <= '0;
		end
		if ((state_q == S_DIV) && div_stat.done) begin
			fill_q <= fill_sat;
		end
	end

	// Output register: one LED per transaction.
	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && load && !cnt_done_q) begin
			led_index_q <= cnt_q;
			hue_q       <= blink_q ? BLINK_HUE : HUE_LUT[cnt_q];
			level_q     <= lv_out;
			last_q      <= (cnt_q == IDX_W'(LED_COUNT - 1));
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign led_index = led_index_q;
	assign hue       = hue_q;
	assign level     = level_q;
	assign last      = last_q;

	// Checks on the sequencer.
	`RLBG_ASSERT_IMP(a_ready_no_result, clk, arst_n, in_ready, !out_valid)
	`RLBG_ASSERT_NXT(a_accept_busy, clk, arst_n, in_fire, !in_ready)
	`RLBG_ASSERT_NXT(a_last_frees, clk, arst_n, out_valid && out_ready && last, in_ready)
	`RLBG_ASSERT_IMP(a_div_in_state, clk, arst_n, div_stat.done || div_stat.busy, state_q == S_DIV)

endmodule
